// File: rtl/core/dsc_pkg.sv
// Shared types, constants and the compare-order helper function of the dual-inverter SVPWM compare block.
`default_nettype none

package dsc_pkg;

  // Fraction bits of a duty value: 1.0 is 2^FRAC_BITS.
  localparam int FRAC_BITS = 16;

  // sqrt(3)/2 in Q30.
  localparam logic [29:0] SQ3H_Q30 = 30'd929887697;

  // Configuration register indexes.
  localparam logic [1:0] REG_PERIOD_ONE = 2'd0;
  localparam logic [1:0] REG_PERIOD_TWO = 2'd1;
  localparam logic [1:0] REG_MIN_PULSE  = 2'd2;

  // Inverter lanes.
  localparam logic LANE_ONE = 1'b0;
  localparam logic LANE_TWO = 1'b1;

  // Sideband of the rescale divider.
  typedef struct packed {
    logic [2:0]  sector;
    logic        ovm;
    logic [15:0] dm;
    logic [15:0] dn;
  } dsc_side2_t;

  // Sideband of the ratio divider.
  typedef struct packed {
    logic [2:0]  sector;
    logic [16:0] dm;
    logic [16:0] dn;
    logic [15:0] d0;
  } dsc_side3_t;

  // One result word: sector and three compare counts per inverter.
  typedef struct packed {
    logic [2:0]            sector;
    logic [1:0][2:0][15:0] cmp;
  } dsc_res_t;

  // Compare-value order of one inverter: three 2-bit picks, first pick on top.
  function automatic logic [5:0] order_code(logic lane, logic [2:0] sector);
    logic [5:0] code;
    code = 6'b00_01_11;
    if (lane == LANE_ONE) begin
      case (sector)
        3'd1: code = 6'b00_01_11;
        3'd2: code = 6'b10_00_11;
        3'd3: code = 6'b11_00_01;
        3'd4: code = 6'b11_10_00;
        3'd5: code = 6'b01_11_00;
        3'd6: code = 6'b00_11_10;
        default: code = 6'b00_01_11;
      endcase
    end else begin
      case (sector)
        3'd1: code = 6'b11_10_00;
        3'd2: code = 6'b01_11_00;
        3'd3: code = 6'b00_11_10;
        3'd4: code = 6'b00_01_11;
        3'd5: code = 6'b10_00_11;
        3'd6: code = 6'b11_00_01;
        default: code = 6'b11_10_00;
      endcase
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes on a shared divisor.
`default_nettype none

module dsc_div #(
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int SW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_a_i,
  input  logic [DW-1:0] rem_b_i,
  input  logic [QW-1:0] low_a_i,
  input  logic [QW-1:0] low_b_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_a_o,
  output logic [QW-1:0] quo_b_o,
  output logic [SW-1:0] side_o
);

  // Stage boundaries: index 0 is the input, index k the output of stage k.
  logic [DW-1:0] ra [QW];
  logic [DW-1:0] rb [QW];
  logic [QW-1:0] la [QW+1];
  logic [QW-1:0] lb [QW+1];
  logic [DW-1:0] dv [QW+1];
  logic [SW-1:0] sd [QW+1];
  logic          vv [QW+1];

  assign ra[0] = rem_a_i;
  assign rb[0] = rem_b_i;
  assign la[0] = low_a_i;
  assign lb[0] = low_b_i;
  assign dv[0] = div_i;
  assign sd[0] = side_i;
  assign vv[0] = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   ta, tb, dd, sa, sb;
    logic          ge_a, ge_b;
    logic [DW-1:0] ra_d, rb_d;
    logic [QW-1:0] la_q, lb_q;
    logic [DW-1:0] dv_q;
    logic [SW-1:0] sd_q;
    logic          vv_q;

    // Shift in the next dividend bit and try to subtract.
    assign ta   = {ra[k], la[k][QW-1]};
    assign tb   = {rb[k], lb[k][QW-1]};
    assign dd   = {1'b0, dv[k]};
    assign sa   = ta - dd;
    assign sb   = tb - dd;
    assign ge_a = (ta >= dd);
    assign ge_b = (tb >= dd);
    assign ra_d = ge_a ? sa[DW-1:0] : ta[DW-1:0];
    assign rb_d = ge_b ? sb[DW-1:0] : tb[DW-1:0];

    // Advance the valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vv_q <= 1'b0;
      end else if (en_i) begin
        vv_q <= vv[k];
      end
    end

    // Advance the data.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        la_q <= {la[k][QW-2:0], ge_a};
        lb_q <= {lb[k][QW-2:0], ge_b};
        dv_q <= dv[k];
        sd_q <= sd[k];
      end
    end

    assign la[k+1] = la_q;
    assign lb[k+1] = lb_q;
    assign dv[k+1] = dv_q;
    assign sd[k+1] = sd_q;
    assign vv[k+1] = vv_q;

    // Hold the partial remainder where a later stage reads it.
    if (k < QW - 1) begin : g_rem
      logic [DW-1:0] ra_q, rb_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ra_q <= ra_d;
          rb_q <= rb_d;
        end
      end
      assign ra[k+1] = ra_q;
      assign rb[k+1] = rb_q;
    end
  end

  assign valid_o = vv[QW];
  assign quo_a_o = la[QW];
  assign quo_b_o = lb[QW];
  assign side_o  = sd[QW];

endmodule

`default_nettype wire

// File: rtl/core/dsc_front.sv
// Sector decision and Q16 duty numerators, two register stages.
`default_nettype none

module dsc_front
  import dsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] v_alpha_i,
  input  logic signed [15:0] v_beta_i,
  input  logic [15:0]        v_dc_i,
  output logic               valid_o,
  output logic [2:0]         sector_o,
  output logic [31:0]        num_m_o,
  output logic [31:0]        num_n_o,
  output logic [15:0]        vdc_o
);

  // Stage one: squares and the sqrt(3)/2 product.
  logic signed [31:0] aa_full, bb_full;
  logic signed [46:0] ca_full;

  assign aa_full = v_alpha_i * v_alpha_i;
  assign bb_full = v_beta_i * v_beta_i;
  assign ca_full = $signed({1'b0, SQ3H_Q30}) * v_alpha_i;

  logic               s1_valid_q;
  logic signed [15:0] a_q, b_q;
  logic [30:0]        aa_q, bb_q;
  logic signed [46:0] ca_q;
  logic [15:0]        vdc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= v_alpha_i;
      b_q    <= v_beta_i;
      aa_q   <= aa_full[30:0];
      bb_q   <= bb_full[30:0];
      ca_q   <= ca_full;
      vdc1_q <= (v_dc_i == 16'd0) ? 16'd1 : v_dc_i;
    end
  end

  // Stage two: slope compares, sector and numerators.
  logic [31:0]        a3, bb32;
  logic               lt, gt;
  logic               apos, aneg, azero, bpos, bneg;
  logic signed [47:0] ca, hb, fb, nm, nn;
  logic [2:0]         sector_d;

  assign a3    = {aa_q, 1'b0} + {1'b0, aa_q};
  assign bb32  = {1'b0, bb_q};
  assign lt    = (bb32 < a3);
  assign gt    = (bb32 > a3);
  assign aneg  = a_q[15];
  assign azero = (a_q == 16'sd0);
  assign apos  = !aneg && !azero;
  assign bneg  = b_q[15];
  assign bpos  = !bneg && (b_q != 16'sd0);
  assign ca    = {ca_q[46], ca_q};
  assign hb    = {{3{b_q[15]}}, b_q, 29'd0};
  assign fb    = {{2{b_q[15]}}, b_q, 30'd0};

  always_comb begin
    sector_d = 3'd1;
    nm       = '0;
    nn       = '0;
    if (apos && !bneg && lt) begin
      sector_d = 3'd1; nm = ca - hb;  nn = fb;
    end else if (bpos && (azero || (apos && !lt) || (aneg && gt))) begin
      sector_d = 3'd2; nm = ca + hb;  nn = hb - ca;
    end else if (aneg && bpos) begin
      sector_d = 3'd3; nm = fb;       nn = -ca - hb;
    end else if (aneg && !bpos && lt) begin
      sector_d = 3'd4; nm = hb - ca;  nn = -fb;
    end else if (bneg && (azero || (aneg && !lt) || (apos && gt))) begin
      sector_d = 3'd5; nm = -ca - hb; nn = ca - hb;
    end else if (apos && bneg) begin
      sector_d = 3'd6; nm = -fb;      nn = ca + hb;
    end
  end

  logic        s2_valid_q;
  logic [2:0]  sector_q;
  logic [31:0] num_m_q, num_n_q;
  logic [15:0] vdc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Clamp negative numerators at zero and drop the Q30 fraction bits below FRAC_BITS.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      num_m_q  <= nm[47] ? 32'd0 : nm[45:30-FRAC_BITS];
      num_n_q  <= nn[47] ? 32'd0 : nn[45:30-FRAC_BITS];
      vdc2_q   <= vdc1_q;
    end
  end

  assign valid_o  = s2_valid_q;
  assign sector_o = sector_q;
  assign num_m_o  = num_m_q;
  assign num_n_o  = num_n_q;
  assign vdc_o    = vdc2_q;

endmodule

`default_nettype wire

// File: rtl/core/dsc_count.sv
// Compare-count products, pinned pattern and per-sector ordering, two register stages.
`default_nettype none

module dsc_count
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [2:0]  sector_i,
  input  logic [16:0] dm_i,
  input  logic [16:0] dn_i,
  input  logic [15:0] d0_i,
  input  logic [16:0] tm_i,
  input  logic [16:0] tn_i,
  input  logic [15:0] period_one_i,
  input  logic [15:0] period_two_i,
  input  logic [14:0] min_pulse_i,
  output logic        valid_o,
  output dsc_res_t    res_o
);

  logic [15:0] prd [2];
  assign prd[0] = period_one_i;
  assign prd[1] = period_two_i;

  logic       c1_valid_q, c2_valid_q;
  logic [2:0] sector_q;
  dsc_res_t   res_q;
  logic [1:0][2:0][15:0] cmp;

  // Shared duty sums.
  logic [17:0] s1, s2;
  logic [18:0] s3;
  assign s1 = {1'b0, dm_i} + {2'b0, d0_i};
  assign s2 = {1'b0, dn_i} + {2'b0, d0_i};
  assign s3 = {1'b0, s1} + {2'b0, dn_i};

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [17:0] span;
    logic [16:0]        mag;
    logic [31:0]        p0_q;
    logic [33:0]        p1_q, p2_q, pm_q, pn_q;
    logic [34:0]        p3_q;
    logic               neg_q;
    logic signed [16:0] hi_q;

    assign span = $signed({2'b0, prd[g]}) - $signed({2'b0, min_pulse_i, 1'b0});
    assign mag  = span[17] ? 17'(-span) : span[16:0];

    // Form all products of the normal and the pinned pattern.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p0_q  <= 32'(prd[g]) * 32'(d0_i);
        p1_q  <= 34'(prd[g]) * 34'(s1);
        p2_q  <= 34'(prd[g]) * 34'(s2);
        p3_q  <= 35'(prd[g]) * 35'(s3);
        pm_q  <= 34'(mag) * 34'(tm_i);
        pn_q  <= 34'(mag) * 34'(tn_i);
        neg_q <= span[17];
        hi_q  <= $signed({1'b0, prd[g]}) - $signed({2'b0, min_pulse_i});
      end
    end

    // Scale, clamp and pick the pattern.
    logic               pin;
    logic [17:0]        pa, pb;
    logic signed [19:0] ma, mb;
    logic [15:0]        vals [4];
    logic [5:0]         code;

    assign pin = (p0_q < {1'b0, min_pulse_i, {FRAC_BITS{1'b0}}});
    assign pa  = pm_q[33:16];
    assign pb  = pn_q[33:16];
    assign ma  = neg_q ? (20'(min_pulse_i) - 20'(pa)) : (20'(min_pulse_i) + 20'(pa));
    assign mb  = neg_q ? (20'(min_pulse_i) - 20'(pb)) : (20'(min_pulse_i) + 20'(pb));

    always_comb begin
      if (pin) begin
        vals[0] = 16'(min_pulse_i);
        vals[1] = ma[19] ? 16'd0 : ((|ma[18:16]) ? 16'hFFFF : ma[15:0]);
        vals[2] = mb[19] ? 16'd0 : ((|mb[18:16]) ? 16'hFFFF : mb[15:0]);
        vals[3] = hi_q[16] ? 16'd0 : hi_q[15:0];
      end else begin
        vals[0] = p0_q[31:16];
        vals[1] = (|p1_q[33:32]) ? 16'hFFFF : p1_q[31:16];
        vals[2] = (|p2_q[33:32]) ? 16'hFFFF : p2_q[31:16];
        vals[3] = (|p3_q[34:32]) ? 16'hFFFF : p3_q[31:16];
      end
    end

    assign code      = order_code(g[0], sector_q);
    assign cmp[g][0] = vals[code[5:4]];
    assign cmp[g][1] = vals[code[3:2]];
    assign cmp[g][2] = vals[code[1:0]];
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
    end else if (en_i) begin
      c1_valid_q <= valid_i;
      c2_valid_q <= c1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q     <= sector_i;
      res_q.sector <= sector_q;
      res_q.cmp    <= cmp;
    end
  end

  assign valid_o = c2_valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/core/dual_inverter_svm_compare.sv
// Top level of the dual-inverter space-vector PWM compare generator.
// Takes one word per cycle (alpha/beta command and DC link) unless the output buffer is full, and
// returns, in order, the sector and three compare counts for each of the two inverters. The
// path from accept to result: sector and numerator stages, a 32-stage duty divider, a register,
// a 17-stage overmodulation rescale divider, a register, a 17-stage ratio divider and the product
// and compare stages. The dividers give one quotient bit per stage. A two-word output buffer lets
// the pipeline keep accepting while a result waits; the whole pipeline holds while it is full.
// Write period_one, period_two and min_pulse only while no word is in flight.
`default_nettype none

module dual_inverter_svm_compare
  import dsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] v_alpha_i,
  input  logic signed [15:0] v_beta_i,
  input  logic [15:0]        v_dc_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         sector_o,
  output logic [15:0]        cmp_one_a_o,
  output logic [15:0]        cmp_one_b_o,
  output logic [15:0]        cmp_one_c_o,
  output logic [15:0]        cmp_two_a_o,
  output logic [15:0]        cmp_two_b_o,
  output logic [15:0]        cmp_two_c_o
);

  // Configuration registers.
  logic [15:0] period_one_q, period_two_q;
  logic [14:0] min_pulse_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_one_q <= 16'd1000;
      period_two_q <= 16'd1000;
      min_pulse_q  <= 15'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PERIOD_ONE: period_one_q <= cfg_data_i;
        REG_PERIOD_TWO: period_two_q <= cfg_data_i;
        REG_MIN_PULSE:  min_pulse_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output buffer is full.
  logic       en;
  logic [1:0] cnt_q;
  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // Sector and numerators.
  logic        f_valid;
  logic [2:0]  f_sector;
  logic [31:0] f_num_m, f_num_n;
  logic [15:0] f_vdc;

  dsc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .v_alpha_i (v_alpha_i),
    .v_beta_i  (v_beta_i),
    .v_dc_i    (v_dc_i),
    .valid_o   (f_valid),
    .sector_o  (f_sector),
    .num_m_o   (f_num_m),
    .num_n_o   (f_num_n),
    .vdc_o     (f_vdc)
  );

  // Raw duties.
  logic        d1_valid;
  logic [31:0] d1_dm, d1_dn;
  logic [2:0]  d1_sector;

  dsc_div #(.DW(16), .QW(32), .SW(3)) u_div_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rem_a_i (16'd0),
    .rem_b_i (16'd0),
    .low_a_i (f_num_m),
    .low_b_i (f_num_n),
    .div_i   (f_vdc),
    .side_i  (f_sector),
    .valid_o (d1_valid),
    .quo_a_o (d1_dm),
    .quo_b_o (d1_dn),
    .side_o  (d1_sector)
  );

  // Duty sum for the overmodulation test.
  logic        r2_valid_q;
  logic [2:0]  r2_sector_q;
  logic [31:0] r2_dm_q, r2_dn_q;
  logic [32:0] r2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_valid_q <= 1'b0;
    end else if (en) begin
      r2_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_sector_q <= d1_sector;
      r2_dm_q     <= d1_dm;
      r2_dn_q     <= d1_dn;
      r2_sum_q    <= {1'b0, d1_dm} + {1'b0, d1_dn};
    end
  end

  dsc_side2_t side2_in, side2_out;
  assign side2_in.sector = r2_sector_q;
  assign side2_in.ovm    = |r2_sum_q[32:FRAC_BITS];
  assign side2_in.dm     = r2_dm_q[15:0];
  assign side2_in.dn     = r2_dn_q[15:0];

  // Rescale to a duty sum of one.
  logic        d2_valid;
  logic [16:0] d2_qm, d2_qn;

  dsc_div #(.DW(33), .QW(17), .SW($bits(dsc_side2_t))) u_div_rescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r2_valid_q),
    .rem_a_i ({2'b0, r2_dm_q[31:1]}),
    .rem_b_i ({2'b0, r2_dn_q[31:1]}),
    .low_a_i ({r2_dm_q[0], {FRAC_BITS{1'b0}}}),
    .low_b_i ({r2_dn_q[0], {FRAC_BITS{1'b0}}}),
    .div_i   (r2_sum_q),
    .side_i  (side2_in),
    .valid_o (d2_valid),
    .quo_a_o (d2_qm),
    .quo_b_o (d2_qn),
    .side_o  (side2_out)
  );

  // Final active duties, half of the zero duty and the sum of the active duties.
  logic [16:0] dmf, dnf, d0_full;
  assign dmf     = side2_out.ovm ? d2_qm : {1'b0, side2_out.dm};
  assign dnf     = side2_out.ovm ? d2_qn : {1'b0, side2_out.dn};
  assign d0_full = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, side2_out.dm} - {1'b0, side2_out.dn};

  logic        r3_valid_q;
  dsc_side3_t  r3_side_q;
  logic [17:0] r3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r3_valid_q <= 1'b0;
    end else if (en) begin
      r3_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_side_q.sector <= side2_out.sector;
      r3_side_q.dm     <= dmf;
      r3_side_q.dn     <= dnf;
      r3_side_q.d0     <= side2_out.ovm ? 16'd0 : d0_full[16:1];
      r3_sum_q         <= {1'b0, dmf} + {1'b0, dnf};
    end
  end

  // Ratios of each active duty to the duty sum for the pinned pattern.
  logic        d3_valid;
  logic [16:0] d3_tm, d3_tn;
  dsc_side3_t  side3_out;

  dsc_div #(.DW(18), .QW(17), .SW($bits(dsc_side3_t))) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r3_valid_q),
    .rem_a_i ({2'b0, r3_side_q.dm[16:1]}),
    .rem_b_i ({2'b0, r3_side_q.dn[16:1]}),
    .low_a_i ({r3_side_q.dm[0], {FRAC_BITS{1'b0}}}),
    .low_b_i ({r3_side_q.dn[0], {FRAC_BITS{1'b0}}}),
    .div_i   (r3_sum_q),
    .side_i  (r3_side_q),
    .valid_o (d3_valid),
    .quo_a_o (d3_tm),
    .quo_b_o (d3_tn),
    .side_o  (side3_out)
  );

  // Drop the ratio when the duty sum is zero.
  logic        sum_zero;
  logic [16:0] tm, tn;
  assign sum_zero = (side3_out.dm == 17'd0) && (side3_out.dn == 17'd0);
  assign tm       = sum_zero ? 17'd0 : d3_tm;
  assign tn       = sum_zero ? 17'd0 : d3_tn;

  logic     c_valid;
  dsc_res_t c_res;

  dsc_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (d3_valid),
    .sector_i     (side3_out.sector),
    .dm_i         (side3_out.dm),
    .dn_i         (side3_out.dn),
    .d0_i         (side3_out.d0),
    .tm_i         (tm),
    .tn_i         (tn),
    .period_one_i (period_one_q),
    .period_two_i (period_two_q),
    .min_pulse_i  (min_pulse_q),
    .valid_o      (c_valid),
    .res_o        (c_res)
  );

  // Two-word output buffer.
  dsc_res_t slot_q [2];
  logic     wptr_q, rptr_q;
  logic     push, pop;

  assign push = c_valid && en;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= c_res;
    end
  end

  dsc_res_t head;
  assign head        = slot_q[rptr_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign sector_o    = head.sector;
  assign cmp_one_a_o = head.cmp[LANE_ONE][0];
  assign cmp_one_b_o = head.cmp[LANE_ONE][1];
  assign cmp_one_c_o = head.cmp[LANE_ONE][2];
  assign cmp_two_a_o = head.cmp[LANE_TWO][0];
  assign cmp_two_b_o = head.cmp[LANE_TWO][1];
  assign cmp_two_c_o = head.cmp[LANE_TWO][2];

  // Buffer never holds more than two words.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  // A full buffer that is not drained stalls the input.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while output buffer full");

  // Every delivered word carries a legal sector.
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_o >= 3'd1 && sector_o <= 3'd6))
    else $error("sector out of range");

  // After a push the output is valid on the next cycle.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("pushed word not visible");

endmodule

`default_nettype wire
